>>> rtl/breakpoint_table_interpolator_macros.svh
// assertion helpers for the checker file
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_MACROS_SVH

// plain property, sampled on clk, off while rst_n is low
`define BTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, sampled on clk, off while rst_n is low
`define BTI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bti_pkg.sv
package bti_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int N_W           = $clog2(TABLE_DEPTH + 1);

    localparam int FIELD_W       = 32;
    localparam int INDEX_FIELD_W = 6;
    localparam int COUNT_FIELD_W = 7;

    localparam int ALPHA_FRAC    = 16;
    localparam int ALPHA_W       = ALPHA_FRAC + 1;
    localparam int DIFF_W        = FIELD_W + 1;
    localparam int PROD_W        = DIFF_W + ALPHA_W + 1;
    localparam int DIV_STEPS     = ALPHA_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    localparam int KEY_LSB       = INDEX_FIELD_W;
    localparam int VALUE_LSB     = KEY_LSB + FIELD_W;
    localparam int QUERY_LSB     = VALUE_LSB + FIELD_W;
    localparam int S_FIELDS_W    = QUERY_LSB + FIELD_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W     = 1;
    localparam int M_TDATA_W     = FIELD_W;
    localparam int M_TUSER_W     = 3;
    localparam int M_ACK_BIT     = 2;

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int REG_SEL_BIT   = 2;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_LOW  = 2'd1;
    localparam logic [1:0] CLAMP_HIGH = 2'd2;

    localparam logic [COUNT_FIELD_W-1:0] ENTRY_COUNT_RESET = 7'd2;
    localparam int MIN_ENTRIES = 2;

    typedef struct packed {
        logic [FIELD_W-1:0] value;
        logic [FIELD_W-1:0] key;
    } entry_t;

endpackage

>>> rtl/breakpoint_table_interpolator.sv
// breakpoint table interpolator
// input stream s_axis_*: tuser selects load (0) or query (1); a load writes one
// (key, value) breakpoint, a query asks for the interpolated value at a key
// output stream m_axis_*: one transfer per input transfer, in order
// apb port: register 0 is entry_count, the number of breakpoints in use
// a load is acknowledged through the finish state and then the output register
// a query scans the table one entry per cycle on a single read port, then
// runs a 17-step restoring divider for alpha, one multiply and one add
// a query scans from one entry up to all entries in use; a clamped query then
// goes to the finish state, an interpolated one through divide, multiply, add
// one item is in flight at a time; s_axis_tready is high only when idle, so
// the next item can be taken in the cycle after a result is posted
// the output register holds one result; a new item is taken while it waits,
// and a finished result waits in the block until the output register frees
// reset clears the control state and sets entry_count to 2; table contents
// are undefined until written
module breakpoint_table_interpolator
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index, entry_key, entry_value, query_key, zero pad
    input  logic [bti_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // mode
    input  logic [bti_pkg::S_TUSER_W-1:0]       s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_value
    output logic [bti_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // clamp_status, load_ack
    output logic [bti_pkg::M_TUSER_W-1:0]       m_axis_tuser,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bti_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bti_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bti_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    localparam int FW = bti_pkg::FIELD_W;

    logic [2:0]                             state_reg, state_next;
    logic [bti_pkg::COUNT_FIELD_W-1:0]      entry_count_reg, entry_count_next;
    logic                                   out_valid_reg, out_valid_next;

    logic [bti_pkg::N_W-1:0]                i_reg, i_next;
    logic signed [FW-1:0]                   q_reg, q_next;
    logic signed [FW-1:0]                   prev_key_reg, prev_key_next;
    logic signed [FW-1:0]                   prev_val_reg, prev_val_next;
    logic [FW-1:0]                          den_reg, den_next;
    logic [FW-1:0]                          rem_reg, rem_next;
    logic [bti_pkg::ALPHA_W-1:0]            sh_reg, sh_next;
    logic [bti_pkg::ALPHA_W-1:0]            alpha_reg, alpha_next;
    logic [bti_pkg::DIV_CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [bti_pkg::DIFF_W-1:0]      diff_reg, diff_next;
    logic signed [bti_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [FW-1:0]                          res_reg, res_next;
    logic [1:0]                             status_reg, status_next;
    logic                                   ack_reg, ack_next;
    logic [FW-1:0]                          out_data_reg, out_data_next;
    logic [1:0]                             out_status_reg, out_status_next;
    logic                                   out_ack_reg, out_ack_next;

    bti_pkg::entry_t                        mem [bti_pkg::TABLE_DEPTH];
    bti_pkg::entry_t                        rd_data_reg;
    logic [bti_pkg::IDX_W-1:0]              rd_addr;
    logic                                   mem_we;

    logic                                   s_mode;
    logic [bti_pkg::INDEX_FIELD_W-1:0]      s_index;
    logic [FW-1:0]                          s_key;
    logic [FW-1:0]                          s_value;
    logic [FW-1:0]                          s_query;

    logic [bti_pkg::N_W-1:0]                used_n;
    logic [bti_pkg::N_W-1:0]                i_plus;
    logic signed [FW-1:0]                   rd_key;
    logic signed [FW-1:0]                   rd_val;
    logic signed [bti_pkg::DIFF_W-1:0]      num;
    logic signed [bti_pkg::DIFF_W-1:0]      den_full;
    logic [FW:0]                            trial;
    logic                                   trial_ge;
    logic signed [bti_pkg::ALPHA_W:0]       alpha_ext;
    logic                                   cfg_we;

    assign s_mode  = s_axis_tuser[0];
    assign s_index = s_axis_tdata[bti_pkg::INDEX_FIELD_W-1:0];
    assign s_key   = s_axis_tdata[bti_pkg::KEY_LSB +: FW];
    assign s_value = s_axis_tdata[bti_pkg::VALUE_LSB +: FW];
    assign s_query = s_axis_tdata[bti_pkg::QUERY_LSB +: FW];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_ack_reg, out_status_reg};

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready
                    & (paddr[bti_pkg::REG_SEL_BIT] == bti_pkg::REG_ENTRY_COUNT);
    assign prdata = (paddr[bti_pkg::REG_SEL_BIT] == bti_pkg::REG_ENTRY_COUNT)
                    ? bti_pkg::APB_DATA_W'(entry_count_reg) : '0;

    always_comb
    begin
        if (int'(entry_count_reg) < bti_pkg::MIN_ENTRIES)
        begin
            used_n = bti_pkg::N_W'(bti_pkg::MIN_ENTRIES);
        end
        else if (int'(entry_count_reg) > bti_pkg::TABLE_DEPTH)
        begin
            used_n = bti_pkg::N_W'(bti_pkg::TABLE_DEPTH);
        end
        else
        begin
            used_n = bti_pkg::N_W'(entry_count_reg);
        end
    end

    assign i_plus    = i_reg + bti_pkg::N_W'(1);
    assign rd_key    = signed'(rd_data_reg.key);
    assign rd_val    = signed'(rd_data_reg.value);
    assign num       = {q_reg[FW-1], q_reg} - {prev_key_reg[FW-1], prev_key_reg};
    assign den_full  = {rd_key[FW-1], rd_key} - {prev_key_reg[FW-1], prev_key_reg};
    assign trial     = {rem_reg, sh_reg[bti_pkg::ALPHA_W-1]};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign alpha_ext = signed'({1'b0, alpha_reg});

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = cfg_we ? pwdata[bti_pkg::COUNT_FIELD_W-1:0] : entry_count_reg;
        out_valid_next   = out_valid_reg;
        i_next           = i_reg;
        q_next           = q_reg;
        prev_key_next    = prev_key_reg;
        prev_val_next    = prev_val_reg;
        den_next         = den_reg;
        rem_next         = rem_reg;
        sh_next          = sh_reg;
        alpha_next       = alpha_reg;
        cnt_next         = cnt_reg;
        diff_next        = diff_reg;
        prod_next        = prod_reg;
        res_next         = res_reg;
        status_next      = status_reg;
        ack_next         = ack_reg;
        out_data_next    = out_data_reg;
        out_status_next  = out_status_reg;
        out_ack_next     = out_ack_reg;
        mem_we           = 1'b0;
        rd_addr          = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_mode == bti_pkg::MODE_LOAD)
                    begin
                        mem_we      = (int'(s_index) < bti_pkg::TABLE_DEPTH);
                        res_next    = '0;
                        status_next = bti_pkg::CLAMP_NONE;
                        ack_next    = 1'b1;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        q_next     = signed'(s_query);
                        i_next     = '0;
                        ack_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // read data holds entry i_reg; fetch the next one meanwhile
                rd_addr = bti_pkg::IDX_W'(i_plus);
                if (rd_key < q_reg)
                begin
                    i_next        = i_plus;
                    prev_key_next = rd_key;
                    prev_val_next = rd_val;
                    if (i_plus >= used_n)
                    begin
                        res_next    = rd_val;
                        status_next = bti_pkg::CLAMP_HIGH;
                        state_next  = ST_FIN;
                    end
                end
                else if (i_reg == '0)
                begin
                    res_next    = rd_val;
                    status_next = bti_pkg::CLAMP_LOW;
                    state_next  = ST_FIN;
                end
                else
                begin
                    // num <= den, so the top part of num << 16 is below den
                    den_next   = den_full[FW-1:0];
                    rem_next   = num[FW:1];
                    sh_next    = {num[0], bti_pkg::ALPHA_FRAC'(0)};
                    alpha_next = '0;
                    cnt_next   = '0;
                    diff_next  = {rd_val[FW-1], rd_val}
                                 - {prev_val_reg[FW-1], prev_val_reg};
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next   = trial_ge ? FW'(trial - {1'b0, den_reg}) : trial[FW-1:0];
                alpha_next = {alpha_reg[bti_pkg::ALPHA_W-2:0], trial_ge};
                sh_next    = sh_reg << 1;
                cnt_next   = cnt_reg + bti_pkg::DIV_CNT_W'(1);
                if (cnt_reg == bti_pkg::DIV_CNT_W'(bti_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = diff_reg * alpha_ext;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                // v1 + floor((v2 - v1) * alpha / 2^16), kept to 32 bits
                res_next    = prev_val_reg
                              + prod_reg[bti_pkg::ALPHA_FRAC +: FW];
                status_next = bti_pkg::CLAMP_NONE;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next   = res_reg;
                    out_status_next = status_reg;
                    out_ack_next    = ack_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= bti_pkg::ENTRY_COUNT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        q_reg          <= q_next;
        prev_key_reg   <= prev_key_next;
        prev_val_reg   <= prev_val_next;
        den_reg        <= den_next;
        rem_reg        <= rem_next;
        sh_reg         <= sh_next;
        alpha_reg      <= alpha_next;
        cnt_reg        <= cnt_next;
        diff_reg       <= diff_next;
        prod_reg       <= prod_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        ack_reg        <= ack_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_ack_reg    <= out_ack_next;
    end

    // breakpoint table, one write and one read address per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[bti_pkg::IDX_W'(s_index)] <= '{value: s_value, key: s_key};
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> rtl/bti_checker.sv
`include "breakpoint_table_interpolator_macros.svh"

module bti_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bti_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic [bti_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    // stalled result holds
    `BTI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // load acknowledge carries zero value and no clamp code
    `BTI_ASSERT_IMPLY(a_ack_clean, m_axis_tvalid && m_axis_tuser[bti_pkg::M_ACK_BIT], (m_axis_tdata == '0) && (m_axis_tuser[1:0] == bti_pkg::CLAMP_NONE), "load acknowledge with payload")

    // clamp code is one of the three defined ones
    `BTI_ASSERT_IMPLY(a_clamp_code, m_axis_tvalid, m_axis_tuser[1:0] != 2'd3, "undefined clamp code")

    // one item in flight: busy right after a transfer in
    `BTI_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

endmodule

bind breakpoint_table_interpolator bti_checker u_bti_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int ITEM_TARGET = 1450;
    localparam logic [bti_pkg::APB_ADDR_W-1:0] ENTRY_COUNT_ADDR =
        bti_pkg::APB_ADDR_W'(bti_pkg::REG_ENTRY_COUNT) << bti_pkg::REG_SEL_BIT;

    typedef struct {
        logic [bti_pkg::FIELD_W-1:0] value;
        logic [1:0]                  clamp;
        logic                        ack;
    } lookup_result_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [bti_pkg::S_TDATA_W-1:0]       s_axis_tdata = '0;
    logic [bti_pkg::S_TUSER_W-1:0]       s_axis_tuser = '0;

    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [bti_pkg::M_TDATA_W-1:0]       m_axis_tdata;
    logic [bti_pkg::M_TUSER_W-1:0]       m_axis_tuser;

    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [bti_pkg::APB_ADDR_W-1:0]      paddr = '0;
    logic [bti_pkg::APB_DATA_W-1:0]      pwdata = '0;
    logic [bti_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;

    // shadow of the block state
    logic signed [bti_pkg::FIELD_W-1:0]  table_key [bti_pkg::TABLE_DEPTH];
    logic signed [bti_pkg::FIELD_W-1:0]  table_value [bti_pkg::TABLE_DEPTH];
    logic [bti_pkg::COUNT_FIELD_W-1:0]   cfg_entry_count = bti_pkg::ENTRY_COUNT_RESET;

    lookup_result_t pending_results [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_hold_cycles = 0;

    int items_sent = 0;
    int load_count = 0;
    int interp_count = 0;
    int low_clamp_count = 0;
    int high_clamp_count = 0;
    int settings_count = 0;
    int results_seen = 0;
    int error_count = 0;

    breakpoint_table_interpolator i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("breakpoint_table_interpolator verification failed");
        $finish;
    end

    function automatic int used_entries();
        int n;
        n = cfg_entry_count;
        if (n < bti_pkg::MIN_ENTRIES)
            n = bti_pkg::MIN_ENTRIES;
        if (n > bti_pkg::TABLE_DEPTH)
            n = bti_pkg::TABLE_DEPTH;
        return n;
    endfunction

    function automatic lookup_result_t interpolate_at(
        logic signed [bti_pkg::FIELD_W-1:0] q);
        lookup_result_t r;
        int n;
        int i;
        longint k1, k2, v1, v2, num, den, alpha, acc;
        n = used_entries();
        i = 0;
        while (i < n && table_key[i] < q)
            i++;
        r.ack = 1'b0;
        if (i == 0)
        begin
            r.value = table_value[0];
            r.clamp = bti_pkg::CLAMP_LOW;
        end
        else if (i >= n)
        begin
            r.value = table_value[n-1];
            r.clamp = bti_pkg::CLAMP_HIGH;
        end
        else
        begin
            k1 = table_key[i-1];
            k2 = table_key[i];
            v1 = table_value[i-1];
            v2 = table_value[i];
            num = longint'(q) - k1;
            den = k2 - k1;
            alpha = (num <<< bti_pkg::ALPHA_FRAC) / den;
            acc = v1 * ((longint'(1) <<< bti_pkg::ALPHA_FRAC) - alpha) + v2 * alpha;
            r.value = bti_pkg::FIELD_W'(acc >>> bti_pkg::ALPHA_FRAC);
            r.clamp = bti_pkg::CLAMP_NONE;
        end
        return r;
    endfunction

    function automatic logic [bti_pkg::FIELD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bti_pkg::FIELD_W-1:0] random_query(int n);
        longint lo, hi, span;
        int j;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                j = $urandom_range(0, n - 2);
                lo = table_key[j];
                hi = table_key[j+1];
                if (hi <= lo)
                    return bti_pkg::FIELD_W'(lo);
                span = hi - lo + 1;
                return bti_pkg::FIELD_W'(lo + longint'($urandom) % span);
            end
            4, 5:    return table_key[$urandom_range(0, n - 1)];
            6:       return $urandom_range(0, 1) ? table_key[0] - 1 : table_key[n-1] + 1;
            7:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic mode,
                             input logic [bti_pkg::INDEX_FIELD_W-1:0] idx,
                             input logic [bti_pkg::FIELD_W-1:0] key,
                             input logic [bti_pkg::FIELD_W-1:0] value,
                             input logic [bti_pkg::FIELD_W-1:0] query);
        logic [bti_pkg::S_TDATA_W-1:0] word;
        lookup_result_t r;
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word = '0;
        word[0 +: bti_pkg::INDEX_FIELD_W] = idx;
        word[bti_pkg::KEY_LSB +: bti_pkg::FIELD_W] = key;
        word[bti_pkg::VALUE_LSB +: bti_pkg::FIELD_W] = value;
        word[bti_pkg::QUERY_LSB +: bti_pkg::FIELD_W] = query;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= mode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (mode == bti_pkg::MODE_LOAD)
        begin
            table_key[idx] = key;
            table_value[idx] = value;
            r.value = '0;
            r.clamp = bti_pkg::CLAMP_NONE;
            r.ack = 1'b1;
            load_count++;
        end
        else
        begin
            r = interpolate_at(query);
            case (r.clamp)
                bti_pkg::CLAMP_LOW:  low_clamp_count++;
                bti_pkg::CLAMP_HIGH: high_clamp_count++;
                default:             interp_count++;
            endcase
        end
        pending_results.push_back(r);
    endtask

    task automatic load_entry(input int idx, input logic [bti_pkg::FIELD_W-1:0] key,
                              input logic [bti_pkg::FIELD_W-1:0] value);
        send_item(bti_pkg::MODE_LOAD, bti_pkg::INDEX_FIELD_W'(idx), key, value, $urandom);
    endtask

    task automatic send_query(input logic [bti_pkg::FIELD_W-1:0] q);
        send_item(bti_pkg::MODE_QUERY, bti_pkg::INDEX_FIELD_W'($urandom), $urandom,
                  $urandom, q);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [bti_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [bti_pkg::APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ENTRY_COUNT_ADDR)
            cfg_entry_count = data[bti_pkg::COUNT_FIELD_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_entry_count(input int count);
        wait_idle();
        write_register(ENTRY_COUNT_ADDR, bti_pkg::APB_DATA_W'(count));
        settings_count++;
    endtask

    // entries 0..n-1 in shuffled order; narrow keys give many equal keys
    task automatic fill_breakpoints(input int n, input bit sorted, input bit narrow);
        int keys [$];
        int order [$];
        for (int j = 0; j < n; j++)
        begin
            if (narrow)
                keys.push_back((int'($urandom_range(0, 63)) - 32) * 4096);
            else
                keys.push_back(int'(random_word()));
            order.push_back(j);
        end
        if (sorted)
            keys.sort();
        order.shuffle();
        foreach (order[j])
            load_entry(order[j], keys[order[j]], random_word());
    endtask

    task automatic check_result();
        lookup_result_t r;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $error("result with nothing expected: value %h tuser %b",
                   m_axis_tdata, m_axis_tuser);
            error_count++;
            return;
        end
        r = pending_results.pop_front();
        if (m_axis_tdata !== r.value)
        begin
            $error("result_value mismatch: expected %h, got %h", r.value, m_axis_tdata);
            error_count++;
        end
        if (m_axis_tuser[1:0] !== r.clamp)
        begin
            $error("clamp_status mismatch: expected %0d, got %0d", r.clamp, m_axis_tuser[1:0]);
            error_count++;
        end
        if (m_axis_tuser[bti_pkg::M_ACK_BIT] !== r.ack)
        begin
            $error("load_ack mismatch: expected %b, got %b", r.ack,
                   m_axis_tuser[bti_pkg::M_ACK_BIT]);
            error_count++;
        end
    endtask

    // result side: random stalls, plus a long hold-off when requested
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 9) : 0;
            stall += rx_hold_cycles;
            rx_hold_cycles = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            check_result();
        end
    end

    task automatic test_two_point_table();
        load_entry(0, -32'sh1_0000, 32'h3_0000);
        load_entry(1, 32'h2_0000, -32'sh1_0000);
        send_query(32'h8000_0000);
        send_query(-32'sh1_0000);
        send_query(-32'sh0_FFFF);
        send_query(32'h0);
        send_query(32'h1_8000);
        send_query(32'h2_0000);
        send_query(32'h2_0001);
        send_query(32'h7FFF_FFFF);
        // widest span with opposite extreme values
        load_entry(0, 32'h8000_0000, 32'h7FFF_FFFF);
        load_entry(1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h0);
        send_query(32'h7FFF_FFFE);
        send_query(32'h8000_0001);
        // counts below the minimum behave as two entries
        set_entry_count(0);
        send_query(32'h4000_0000);
        set_entry_count(1);
        send_query(32'hC000_0000);
    endtask

    task automatic test_full_table();
        set_entry_count(bti_pkg::TABLE_DEPTH);
        fill_breakpoints(bti_pkg::TABLE_DEPTH, 1'b1, 1'b0);
        repeat (20) send_query(random_query(bti_pkg::TABLE_DEPTH));
        // counts above the depth behave as a full table
        set_entry_count(127);
        repeat (10) send_query(random_query(bti_pkg::TABLE_DEPTH));
        set_entry_count(bti_pkg::TABLE_DEPTH + 1);
        repeat (10) send_query(random_query(bti_pkg::TABLE_DEPTH));
    endtask

    task automatic test_backpressure();
        int n;
        n = used_entries();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 400;
        repeat (16)
        begin
            if ($urandom_range(0, 3) == 0)
                load_entry($urandom_range(0, n - 1), random_word(), random_word());
            else
                send_query(random_query(n));
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_tables();
        int n;
        int count;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(33, bti_pkg::TABLE_DEPTH);
                1, 2:    n = $urandom_range(9, 32);
                default: n = $urandom_range(bti_pkg::MIN_ENTRIES, 8);
            endcase
            count = n;
            if (n == bti_pkg::MIN_ENTRIES && $urandom_range(0, 1))
                count = $urandom_range(0, 1);
            if (n == bti_pkg::TABLE_DEPTH && $urandom_range(0, 1))
                count = $urandom_range(bti_pkg::TABLE_DEPTH + 1, 127);
            set_entry_count(count);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            fill_breakpoints(n, $urandom_range(0, 5) != 0, $urandom_range(0, 3) == 0);
            repeat ($urandom_range(8, 30))
            begin
                if ($urandom_range(0, 9) != 0)
                    send_query(random_query(n));
                else if (n < bti_pkg::TABLE_DEPTH && $urandom_range(0, 1))
                    load_entry($urandom_range(n, bti_pkg::TABLE_DEPTH - 1), random_word(),
                               random_word());
                else
                    load_entry($urandom_range(0, n - 1), random_word(), random_word());
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_two_point_table();
        test_full_table();
        test_backpressure();
        test_random_tables();
        wait_idle();
        repeat (40) @(posedge clk);
        $display("sent %0d table writes and %0d lookups over %0d entry_count settings",
                 load_count, interp_count + low_clamp_count + high_clamp_count,
                 settings_count);
        $display("lookups: %0d interpolated, %0d clamped low, %0d clamped high; %0d checked",
                 interp_count, low_clamp_count, high_clamp_count, results_seen);
        if (error_count == 0)
            $display("breakpoint_table_interpolator verification clean");
        else
            $display("breakpoint_table_interpolator verification failed");
        $finish;
    end

endmodule
